// File: rtl/core/nfs_pkg.sv
package nfs_pkg;

    localparam int MAX_SECTIONS = 256;
    localparam int MAX_LINES    = 64;

    localparam int SEC_W     = $clog2(MAX_SECTIONS);
    localparam int SEC_CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int LINE_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LCNT_W    = $clog2(MAX_LINES + 1);

    localparam int SEG_DEPTH  = (2 ** SEC_W) * (2 ** LINE_W);
    localparam int INFO_DEPTH = 2 ** SEC_W;

    localparam int X_W      = 20;
    localparam int X2_W     = X_W + 1;
    localparam int DIST_W   = X_W + 2;
    localparam int CORR_W   = 16;
    localparam int TOL_W    = CORR_W + X_W;
    localparam int SCALE_SH = 7;
    localparam int CFG_W    = 20;

    localparam logic [1:0] CFG_SECTION_COUNT   = 2'd0;
    localparam logic [1:0] CFG_GLOBAL_STEP     = 2'd1;
    localparam logic [1:0] CFG_STEP_CORRECTION = 2'd2;

    localparam logic [15:0] STEP_CORR_RESET = 16'd256;

    typedef enum logic [1:0] {
        OP_SEG_WR  = 2'd0,
        OP_INFO_WR = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOL,
        S_NEXT,
        S_INFO,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  section;
        logic [5:0]  line;
        logic [19:0] x_pos;
        logic [19:0] seg_width;
        logic [6:0]  line_count;
        logic [19:0] ave_step;
        logic        step_known;
        logic        direction;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] match_section;
        logic [5:0] match_line;
    } t_out_item;

    typedef struct packed {
        logic [X_W-1:0] left;
        logic [X_W-1:0] width;
    } t_seg;

    typedef struct packed {
        logic [6:0]     line_count;
        logic [X_W-1:0] ave_step;
        logic           step_known;
    } t_info;

    typedef struct packed {
        logic clear;
        logic update;
    } t_near_ctl;

endpackage

// File: rtl/core/nearest_fringe_section_search_top.sv
// nearest fringe section search
// input channel i_in_valid / o_in_ready carries one item (t_in_item): a segment
// write, a section info write or a query. writes give no result.
// a query gives exactly one result item (t_out_item) on o_out_valid / i_out_ready.
// configuration registers are written through i_cfg_wr_en / i_cfg_index /
// i_cfg_wdata; the user must write them only while no item is in flight, and the
// block does not enforce this. a query reads the queried section's info and
// forms the tolerance, then walks the neighbor sections one at a time: it
// fetches a section's info and, for a section with segments, reads them one
// after another through the single segment memory port and then decides on a
// match; a section with no segments is skipped without a decision. the walk
// ends at a match or at the end of the section range, and the result is then
// posted.
// one item is worked on at a time and o_in_ready is low during a query.
// the result sits in an output register; a finished query waits, with o_in_ready
// low, until the previous result is taken, and further items are then accepted.
// reset sets the configuration to its reset values and clears the section info
// valid bits and the output valid flag; the segment memory is not cleared and needs no clearing pass.
module nearest_fringe_section_search_top
    import nfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    localparam int SEG_AW = SEC_W + LINE_W;

    // configuration
    logic [8:0]        r_section_count;
    logic [X_W-1:0]    r_global_step;
    logic [CORR_W-1:0] r_step_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= '0;
            r_global_step   <= '0;
            r_step_corr     <= STEP_CORR_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SECTION_COUNT:   r_section_count <= i_cfg_wdata[8:0];
                CFG_GLOBAL_STEP:     r_global_step   <= i_cfg_wdata[X_W-1:0];
                CFG_STEP_CORRECTION: r_step_corr     <= i_cfg_wdata[CORR_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SEC_CNT_W-1:0] used_sections;

    always_comb begin
        if (int'(r_section_count) > MAX_SECTIONS) begin
            used_sections = SEC_CNT_W'(MAX_SECTIONS);
        end else begin
            used_sections = SEC_CNT_W'(r_section_count);
        end
    end

    // sequencer registers
    t_state               r_state, n_state;
    logic [SEC_W-1:0]     r_sec, n_sec;
    logic [SEC_W-1:0]     r_walk, n_walk;
    logic [SEC_CNT_W-1:0] r_cur, n_cur;
    logic                 r_dir, n_dir;
    logic [X2_W-1:0]      r_x2, n_x2;
    logic [TOL_W-1:0]     r_tol, n_tol;
    logic [LCNT_W-1:0]    r_n, n_n;
    logic [LCNT_W-1:0]    r_rd_line, n_rd_line;
    t_out_item            r_res, n_res;

    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic                 out_load;

    logic [MAX_SECTIONS-1:0] r_info_vld;

    // memory ports
    logic              seg_wr_en;
    logic [SEG_AW-1:0] seg_wr_addr;
    t_seg              seg_wr_data;
    logic              seg_rd_en;
    logic [SEG_AW-1:0] seg_rd_addr;
    t_seg              seg_rd_data;

    logic              info_wr_en;
    logic [SEC_W-1:0]  info_wr_addr;
    t_info             info_wr_data;
    logic              info_rd_en;
    logic [SEC_W-1:0]  info_rd_addr;
    t_info             info_rd_data;

    t_near_ctl         near_ctl;
    logic              near_have;
    logic [DIST_W-1:0] near_best;
    logic [LINE_W-1:0] near_best_line;

    logic              in_acc;
    logic              sec_ok;
    logic              line_ok;
    logic [X_W-1:0]    step;
    logic [LCNT_W-1:0] lc_clamp;
    logic [SEC_W-1:0]  next_sec;
    logic [LCNT_W-1:0] next_line;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign sec_ok     = int'(i_in_item.section) < MAX_SECTIONS;
    assign line_ok    = int'(i_in_item.line) < MAX_LINES;

    // write items
    assign seg_wr_en   = in_acc && (t_op'(i_in_item.op) == OP_SEG_WR) && sec_ok && line_ok;
    assign seg_wr_addr = {SEC_W'(i_in_item.section), LINE_W'(i_in_item.line)};
    assign seg_wr_data = '{left: i_in_item.x_pos, width: i_in_item.seg_width};

    assign info_wr_en   = in_acc && (t_op'(i_in_item.op) == OP_INFO_WR) && sec_ok;
    assign info_wr_addr = SEC_W'(i_in_item.section);
    assign info_wr_data = '{line_count: i_in_item.line_count,
                            ave_step:   i_in_item.ave_step,
                            step_known: i_in_item.step_known};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info_vld <= '0;
        end else if (info_wr_en) begin
            r_info_vld[info_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        step = (r_info_vld[r_sec] && info_rd_data.step_known) ? info_rd_data.ave_step
                                                              : r_global_step;
        if (!r_info_vld[r_walk]) begin
            lc_clamp = '0;
        end else if (int'(info_rd_data.line_count) > MAX_LINES) begin
            lc_clamp = LCNT_W'(MAX_LINES);
        end else begin
            lc_clamp = LCNT_W'(info_rd_data.line_count);
        end
        next_sec  = r_dir ? SEC_W'(r_cur) : SEC_W'(r_cur - 1'b1);
        next_line = LCNT_W'(r_rd_line + 1'b1);
    end

    always_comb begin
        n_state   = r_state;
        n_sec     = r_sec;
        n_walk    = r_walk;
        n_cur     = r_cur;
        n_dir     = r_dir;
        n_x2      = r_x2;
        n_tol     = r_tol;
        n_n       = r_n;
        n_rd_line = r_rd_line;
        n_res     = r_res;
        info_rd_en   = 1'b0;
        info_rd_addr = r_walk;
        seg_rd_en    = 1'b0;
        seg_rd_addr  = {r_walk, r_rd_line[LINE_W-1:0]};
        near_ctl     = '{clear: 1'b0, update: 1'b0};
        out_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (t_op'(i_in_item.op) == OP_QUERY)) begin
                    n_res = '0;
                    n_x2  = {i_in_item.x_pos, 1'b0};
                    n_dir = i_in_item.direction;
                    n_sec = SEC_W'(i_in_item.section);
                    if (sec_ok) begin
                        info_rd_en   = 1'b1;
                        info_rd_addr = SEC_W'(i_in_item.section);
                        n_state      = S_TOL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TOL: begin
                n_tol = TOL_W'(r_step_corr) * TOL_W'(step);
                if (r_dir) begin
                    n_cur = SEC_CNT_W'(r_sec) + SEC_CNT_W'(1);
                end else if (SEC_CNT_W'(r_sec) < used_sections) begin
                    n_cur = SEC_CNT_W'(r_sec);
                end else begin
                    n_cur = used_sections;
                end
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if ((r_dir && (r_cur >= used_sections)) || (!r_dir && (r_cur == '0))) begin
                    n_state = S_DONE;
                end else begin
                    n_walk       = next_sec;
                    n_cur        = r_dir ? SEC_CNT_W'(r_cur + 1'b1) : SEC_CNT_W'(r_cur - 1'b1);
                    info_rd_en   = 1'b1;
                    info_rd_addr = next_sec;
                    n_state      = S_INFO;
                end
            end
            S_INFO: begin
                near_ctl.clear = 1'b1;
                n_n            = lc_clamp;
                n_rd_line      = '0;
                if (lc_clamp == '0) begin
                    n_state = S_NEXT;
                end else begin
                    seg_rd_en   = 1'b1;
                    seg_rd_addr = {r_walk, {LINE_W{1'b0}}};
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                near_ctl.update = 1'b1;
                if (next_line < r_n) begin
                    seg_rd_en   = 1'b1;
                    seg_rd_addr = {r_walk, next_line[LINE_W-1:0]};
                    n_rd_line   = next_line;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (near_have && (TOL_W'({near_best, {SCALE_SH{1'b0}}}) < r_tol)) begin
                    n_res   = '{found: 1'b1,
                                match_section: 8'(r_walk),
                                match_line: 6'(near_best_line)};
                    n_state = S_DONE;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec     <= n_sec;
        r_walk    <= n_walk;
        r_cur     <= n_cur;
        r_dir     <= n_dir;
        r_x2      <= n_x2;
        r_tol     <= n_tol;
        r_n       <= n_n;
        r_rd_line <= n_rd_line;
        r_res     <= n_res;
        if (out_load) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    nfs_ram #(
        .WIDTH ($bits(t_seg)),
        .DEPTH (SEG_DEPTH)
    ) u_seg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (seg_wr_en),
        .i_wr_addr (seg_wr_addr),
        .i_wr_data (seg_wr_data),
        .i_rd_en   (seg_rd_en),
        .i_rd_addr (seg_rd_addr),
        .o_rd_data (seg_rd_data)
    );

    nfs_ram #(
        .WIDTH ($bits(t_info)),
        .DEPTH (INFO_DEPTH)
    ) u_info_ram (
        .i_clk     (i_clk),
        .i_wr_en   (info_wr_en),
        .i_wr_addr (info_wr_addr),
        .i_wr_data (info_wr_data),
        .i_rd_en   (info_rd_en),
        .i_rd_addr (info_rd_addr),
        .o_rd_data (info_rd_data)
    );

    nfs_near u_near (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (near_ctl),
        .i_x2        (r_x2),
        .i_seg       (seg_rd_data),
        .i_line      (r_rd_line[LINE_W-1:0]),
        .o_have      (near_have),
        .o_best      (near_best),
        .o_best_line (near_best_line)
    );

    a_scan_line_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_line < r_n))
        else $error("segment scan past line count");

    a_walk_not_queried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_walk != r_sec))
        else $error("walk visited the queried section");

    a_query_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (t_op'(i_in_item.op) == OP_QUERY)) |=> !o_in_ready)
        else $error("input taken right after a query");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |->
        ((o_out_item.match_section == '0) && (o_out_item.match_line == '0)))
        else $error("no-match result carries nonzero fields");

endmodule

// File: rtl/core/nfs_ram.sv
module nfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/nfs_near.sv
module nfs_near
    import nfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_near_ctl         i_ctl,
    input  logic [X2_W-1:0]   i_x2,
    input  t_seg              i_seg,
    input  logic [LINE_W-1:0] i_line,
    output logic              o_have,
    output logic [DIST_W-1:0] o_best,
    output logic [LINE_W-1:0] o_best_line
);

    logic              r_have;
    logic [DIST_W-1:0] r_best;
    logic [LINE_W-1:0] r_best_line;

    logic [DIST_W-1:0] c2;
    logic [DIST_W-1:0] x2_ext;
    logic [DIST_W-1:0] seg_dist;
    logic              take;

    always_comb begin
        c2       = DIST_W'({i_seg.left, 1'b0}) + DIST_W'(i_seg.width);
        x2_ext   = DIST_W'(i_x2);
        seg_dist = (x2_ext > c2) ? (x2_ext - c2) : (c2 - x2_ext);
        // zero-width segments skipped, first of equal minima kept
        take     = i_ctl.update && (i_seg.width != '0) && (!r_have || (seg_dist < r_best));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best      <= seg_dist;
            r_best_line <= i_line;
        end
    end

    assign o_have      = r_have;
    assign o_best      = r_best;
    assign o_best_line = r_best_line;

endmodule
